// File: hw/rtl/srt_pkg.sv
// Shared types and codes for the segment reassembly tracker.
// No dependencies.
package srt_pkg;

    localparam logic [2:0] OP_SEG_BYTE  = 3'd0;
    localparam logic [2:0] OP_EMPTY_SEG = 3'd1;
    localparam logic [2:0] OP_TICK      = 3'd2;
    localparam logic [2:0] OP_CLEAR     = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_INCOMPL   = 3'd3;
    localparam logic [2:0] ST_BEYOND    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WINIT,
        S_WALK,
        S_RD1,
        S_RD2,
        S_OUT
    } t_state;

    // command from the sequencer to every cell
    typedef struct packed {
        logic clear;
        logic wr;
        logic walk_init;
        logic walk_step;
    } t_cell_cmd;

    // priority chains running along the cell row
    typedef struct packed {
        logic match;
        logic free;
        logic walk;
        logic rd;
    } t_chain;

endpackage

// File: hw/rtl/segment_reassembly_tracker.sv
// Top level of the segment reassembly tracker: sequencer, cell row, byte RAM.
// Depends on srt_pkg, srt_cell, srt_ram.
//
// Channel  Dir  Contents
// s_axis   in   tuser=op, tdata=offset/more/byte/index, tlast=seg_end
// m_axis   out  tuser=status, tdata=complete/timed_out/count/size/read_data
// i_cfg    in   timeout_ticks write
//
// One transfer is worked at a time: accept, execute, walk init, then the
// completeness walk (one chain step per cycle, until segment_count steps are
// done or the chain breaks), a read through the byte RAM port (S_RD1, S_RD2)
// for a message read only, and the output state.
// Reset is synchronous; no clearing pass (byte RAM is guarded by lengths).
// A stalled m_axis holds the result and keeps s_axis_tready low.
module segment_reassembly_tracker import srt_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int SEG_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // seg_offset[31:0], more_segments, data_byte,
                                       // byte_index[13:0], zero pad
    input  logic [2:0]  s_axis_tuser,  // op
    input  logic        s_axis_tlast,  // seg_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // complete, timed_out, segment_count[4:0],
                                       // expected_size[31:0], read_data[7:0], zero pad
    output logic [2:0]  m_axis_tuser,  // status
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = $clog2(SEG_BYTES + 1);
    localparam int D  = SLOTS * SEG_BYTES;
    localparam int AW = $clog2(D);

    t_state       r_state, n_state;

    // latched input transfer
    logic [2:0]   r_op;
    logic [31:0]  r_off;
    logic         r_more, r_send;
    logic [7:0]   r_byte;
    logic [13:0]  r_idx;

    logic [31:0]  r_timeout;
    logic         r_final, r_started, r_filling;
    logic [31:0]  r_msize, r_elapsed;
    logic [SW-1:0] r_fill_slot;
    logic [CW-1:0] r_cnt, r_k;
    logic [32:0]  r_covered;
    logic         r_done;
    logic [2:0]   r_status;
    logic [7:0]   r_rd;

    // cell row
    t_cell_cmd    w_cmd;
    t_chain       w_chain [SLOTS+1];
    t_chain       w_sel   [SLOTS];
    logic         w_valid [SLOTS];
    logic [31:0]  w_start [SLOTS];
    logic [LW-1:0] w_len  [SLOTS];
    logic [LW-1:0] w_rdoff[SLOTS];
    logic [SLOTS-1:0] w_wr_sel;
    logic [31:0]  w_wr_start;
    logic [LW-1:0] w_wr_len;

    assign w_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            srt_cell #(.LW(LW)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_wr_sel   (w_wr_sel[g]),
                .i_wr_start (w_wr_start),
                .i_wr_len   (w_wr_len),
                .i_key      (r_off),
                .i_covered  (r_covered),
                .i_idx      (r_idx),
                .i_chain    (w_chain[g]),
                .o_chain    (w_chain[g+1]),
                .o_sel      (w_sel[g]),
                .o_valid    (w_valid[g]),
                .o_start    (w_start[g]),
                .o_len      (w_len[g]),
                .o_rd_off   (w_rdoff[g])
            );
        end
    endgenerate

    // one-hot picks encoded, and selected cell fields
    logic [SW-1:0] w_match_idx, w_free_idx, w_rd_idx;
    logic [LW-1:0] w_walk_len, w_rd_off, w_fill_len;
    logic [31:0]   w_fill_start;
    always_comb begin
        w_match_idx  = '0;
        w_free_idx   = '0;
        w_rd_idx     = '0;
        w_walk_len   = '0;
        w_rd_off     = '0;
        w_fill_len   = '0;
        w_fill_start = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_sel[i].match) w_match_idx = SW'(i);
            if (w_sel[i].free)  w_free_idx  = SW'(i);
            if (w_sel[i].rd) begin
                w_rd_idx = SW'(i);
                w_rd_off = w_rdoff[i];
            end
            if (w_sel[i].walk) w_walk_len = w_len[i];
            if (r_fill_slot == SW'(i)) begin
                w_fill_len   = w_len[i];
                w_fill_start = w_start[i];
            end
        end
    end

    logic w_any_match, w_any_free, w_any_walk, w_any_rd;
    assign w_any_match = w_chain[SLOTS].match;
    assign w_any_free  = w_chain[SLOTS].free;
    assign w_any_walk  = w_chain[SLOTS].walk;
    assign w_any_rd    = w_chain[SLOTS].rd;

    // segment byte / empty segment slot choice
    logic          w_found, w_is_seg;
    logic [SW-1:0] w_lk_idx, w_eff_slot;
    logic [LW-1:0] w_eff_len, w_new_len;
    logic [31:0]   w_eff_start, w_end_size;
    logic [32:0]   w_end_sum;
    logic          w_room;

    assign w_is_seg    = (r_op == OP_SEG_BYTE);
    assign w_found     = w_any_match || w_any_free;
    assign w_lk_idx    = w_any_match ? w_match_idx : w_free_idx;
    assign w_eff_slot  = (w_is_seg && r_filling) ? r_fill_slot : w_lk_idx;
    assign w_eff_len   = (w_is_seg && r_filling) ? w_fill_len : '0;
    assign w_eff_start = (w_is_seg && r_filling) ? w_fill_start : r_off;
    assign w_room      = w_is_seg && (w_eff_len < LW'(SEG_BYTES));
    assign w_new_len   = w_room ? w_eff_len + LW'(1) : w_eff_len;
    assign w_end_sum   = {1'b0, w_eff_start} + {{(33-LW){1'b0}}, w_new_len};
    assign w_end_size  = w_end_sum[32] ? 32'hFFFF_FFFF : w_end_sum[31:0];

    logic w_slot_ok, w_do_wr;
    assign w_slot_ok = (w_is_seg && r_filling) || w_found;
    assign w_do_wr   = (r_state == S_EXEC) && w_slot_ok
                       && (w_is_seg || r_op == OP_EMPTY_SEG);

    // status of the execute step: no slot, or byte past the slot limit
    logic [2:0] w_exec_status;
    always_comb begin
        w_exec_status = ST_OK;
        if ((w_is_seg || r_op == OP_EMPTY_SEG) && !w_slot_ok) begin
            w_exec_status = ST_FULL;
        end else if (w_is_seg && !w_room) begin
            w_exec_status = ST_TOO_LONG;
        end
    end

    always_comb begin
        w_wr_sel = '0;
        w_wr_sel[w_eff_slot] = 1'b1;
    end
    assign w_wr_start = w_eff_start;
    assign w_wr_len   = w_new_len;

    always_comb begin
        w_cmd           = '0;
        w_cmd.clear     = (r_state == S_EXEC) && (r_op == OP_CLEAR);
        w_cmd.wr        = w_do_wr;
        w_cmd.walk_init = (r_state == S_WINIT);
        w_cmd.walk_step = (r_state == S_WALK);
    end

    // byte store
    logic [AW-1:0] w_waddr, w_raddr_n;
    logic [7:0]    w_rdata;
    assign w_waddr   = AW'(w_eff_slot) * AW'(SEG_BYTES) + AW'(w_eff_len);
    assign w_raddr_n = AW'(w_rd_idx) * AW'(SEG_BYTES) + AW'(w_rd_off);

    srt_ram #(.W(8), .D(D)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_do_wr && w_room),
        .i_waddr (w_waddr),
        .i_wdata (r_byte),
        .i_raddr (w_raddr_n),
        .o_rdata (w_rdata)
    );

    logic w_walk_end;
    assign w_walk_end = (r_k == r_cnt) || !w_any_walk;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_EXEC;
            S_EXEC:  n_state = S_WINIT;
            S_WINIT: n_state = S_WALK;
            S_WALK: begin
                if (w_walk_end) n_state = (r_op == OP_READ) ? S_RD1 : S_OUT;
            end
            S_RD1: begin
                if (r_done && ({18'd0, r_idx} < r_msize) && w_any_rd) n_state = S_RD2;
                else n_state = S_OUT;
            end
            S_RD2:   n_state = S_OUT;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 32'd1000;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // input latch
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op   <= s_axis_tuser;
            r_off  <= s_axis_tdata[31:0];
            r_more <= s_axis_tdata[32];
            r_byte <= s_axis_tdata[40:33];
            r_idx  <= s_axis_tdata[54:41];
            r_send <= s_axis_tlast;
        end
    end

    // tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final     <= 1'b0;
            r_started   <= 1'b0;
            r_filling   <= 1'b0;
            r_msize     <= '0;
            r_elapsed   <= '0;
            r_fill_slot <= '0;
            r_cnt       <= '0;
            r_status    <= ST_OK;
        end else if (r_state == S_EXEC) begin
            r_status <= w_exec_status;
            case (r_op)
                OP_SEG_BYTE: begin
                    r_started <= 1'b1;
                    if (w_slot_ok) begin
                        if (!r_filling && !w_any_match) r_cnt <= r_cnt + CW'(1);
                        r_fill_slot <= w_eff_slot;
                        r_filling   <= !r_send;
                        if (r_send && !r_more) begin
                            r_final <= 1'b1;
                            r_msize <= w_end_size;
                        end
                    end
                end
                OP_EMPTY_SEG: begin
                    r_filling <= 1'b0;
                    r_started <= 1'b1;
                    if (w_found) begin
                        if (!w_any_match) r_cnt <= r_cnt + CW'(1);
                        if (!r_more) begin
                            r_final <= 1'b1;
                            r_msize <= w_end_size;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_started && r_elapsed != 32'hFFFF_FFFF) begin
                        r_elapsed <= r_elapsed + 32'd1;
                    end
                end
                OP_CLEAR: begin
                    r_final     <= 1'b0;
                    r_started   <= 1'b0;
                    r_filling   <= 1'b0;
                    r_msize     <= '0;
                    r_elapsed   <= '0;
                    r_fill_slot <= '0;
                    r_cnt       <= '0;
                end
                default: ;
            endcase
        end else if (r_state == S_RD1) begin
            if (!r_done) r_status <= ST_INCOMPL;
            else if (({18'd0, r_idx} >= r_msize) || !w_any_rd) r_status <= ST_BEYOND;
        end
    end

    // completeness walk: one exact-offset hop per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_WINIT: begin
                r_covered <= '0;
                r_k       <= '0;
            end
            S_WALK: begin
                if (r_k == r_cnt) begin
                    r_done <= r_final && (r_covered == {1'b0, r_msize});
                end else if (!w_any_walk) begin
                    r_done <= 1'b0;
                end else begin
                    r_covered <= r_covered + {{(33-LW){1'b0}}, w_walk_len};
                    r_k       <= r_k + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // message read
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_rd <= '0;
        end else if (r_state == S_RD2) begin
            r_rd <= w_rdata;
        end
    end

    // result
    logic [4:0] w_cnt_out;
    logic       w_tout;
    assign w_cnt_out = (r_cnt > CW'(31)) ? 5'd31 : 5'(r_cnt);
    assign w_tout    = r_started && (r_elapsed > r_timeout);
    assign m_axis_tdata = {1'b0, r_rd, r_msize, w_cnt_out, w_tout, r_done};
    assign m_axis_tuser = r_status;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SLOTS))
        else $error("slot count above table size");
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_filling && r_state == S_IDLE) |-> w_valid[r_fill_slot])
        else $error("filling an invalid slot");
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_EXEC))
        else $error("accepted transfer not executed");
`endif
endmodule

// File: hw/rtl/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srt_ram #(
    parameter int W = 8,
    parameter int D = 16384
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/srt_cell.sv
// One slot of the segment table: valid, start offset, length, walk mark.
// Depends on srt_pkg.
module srt_cell import srt_pkg::*; #(
    parameter int LW = 11
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_cmd       i_cmd,
    input  logic            i_wr_sel,
    input  logic [31:0]     i_wr_start,
    input  logic [LW-1:0]   i_wr_len,
    input  logic [31:0]     i_key,
    input  logic [32:0]     i_covered,
    input  logic [13:0]     i_idx,
    input  t_chain          i_chain,
    output t_chain          o_chain,
    output t_chain          o_sel,
    output logic            o_valid,
    output logic [31:0]     o_start,
    output logic [LW-1:0]   o_len,
    output logic [LW-1:0]   o_rd_off
);
    logic          r_valid, r_seen;
    logic [31:0]   r_start;
    logic [LW-1:0] r_len;
    t_chain        w_mine;
    logic [31:0]   w_diff;

    assign w_diff = {18'd0, i_idx} - r_start;

    always_comb begin
        w_mine.match = r_valid && (r_start == i_key);
        w_mine.free  = !r_valid;
        w_mine.walk  = r_valid && !r_seen && ({1'b0, r_start} == i_covered);
        w_mine.rd    = r_valid && (r_len != '0) && ({18'd0, i_idx} >= r_start)
                       && (w_diff < {{(32-LW){1'b0}}, r_len});
        o_sel   = w_mine & ~i_chain;
        o_chain = w_mine | i_chain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            if (i_cmd.wr && i_wr_sel) begin
                r_valid <= 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_seen <= 1'b0;
            end else if (i_cmd.walk_step && o_sel.walk) begin
                r_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && i_wr_sel) begin
            r_start <= i_wr_start;
            r_len   <= i_wr_len;
        end
    end

    assign o_valid  = r_valid;
    assign o_start  = r_start;
    assign o_len    = r_len;
    assign o_rd_off = w_diff[LW-1:0];
endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for segment_reassembly_tracker.
// Depends on srt_pkg and the tracker RTL; contains its own tracker predictor.
`timescale 1ns / 100ps

module tb_top;
    import srt_pkg::*;

    localparam int SLOTS     = 16;
    localparam int SEG_BYTES = 1024;
    localparam int TARGET    = 1500;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] seg_off;
        logic        more;
        logic [7:0]  data;
        logic        seg_end;
        logic [13:0] idx;
    } t_item;

    typedef struct {
        logic        complete;
        logic        timed_out;
        logic [4:0]  count;
        logic [31:0] size;
        logic [7:0]  rdata;
        logic [2:0]  status;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;  // seg_offset[31:0], more, data_byte, byte_index, pad
    logic [2:0]  s_axis_tuser = '0;  // op
    logic        s_axis_tlast = 1'b0; // seg_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;  // complete, timed_out, count[4:0], size[31:0], read_data, pad
    logic [2:0]  m_axis_tuser;  // status
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    segment_reassembly_tracker #(.SLOTS(SLOTS), .SEG_BYTES(SEG_BYTES)) u_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- tracker predictor state ----------------
    logic        trk_valid [SLOTS];
    logic [31:0] trk_start [SLOTS];
    int          trk_len   [SLOTS];
    logic [7:0]  trk_bytes [SLOTS*SEG_BYTES];
    logic        trk_final;
    logic [31:0] trk_size;
    logic        trk_started;
    logic [31:0] trk_elapsed;
    logic        trk_filling;
    int          trk_fill;
    logic [31:0] trk_timeout;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      error_count = 0;
    int      accepted = 0;
    int      results_seen = 0;
    int      completes_seen = 0;
    int      good_reads = 0;
    longint  cycle = 0;

    function automatic void clear_tracker();
        for (int i = 0; i < SLOTS; i++) begin
            trk_valid[i] = 1'b0;
            trk_start[i] = '0;
            trk_len[i]   = 0;
        end
        trk_final   = 1'b0;
        trk_size    = '0;
        trk_started = 1'b0;
        trk_elapsed = '0;
        trk_filling = 1'b0;
        trk_fill    = 0;
    endfunction

    // match on offset empties the slot, else lowest free slot; -1 when full
    function automatic int claim_slot(logic [31:0] off);
        for (int i = 0; i < SLOTS; i++)
            if (trk_valid[i] && trk_start[i] == off) begin
                trk_len[i] = 0;
                return i;
            end
        for (int i = 0; i < SLOTS; i++)
            if (!trk_valid[i]) begin
                trk_valid[i] = 1'b1;
                trk_start[i] = off;
                trk_len[i]   = 0;
                return i;
            end
        return -1;
    endfunction

    function automatic void close_segment(int s, logic more);
        longint unsigned e;
        if (!more) begin
            e = longint'(trk_start[s]) + trk_len[s];
            trk_final = 1'b1;
            trk_size  = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
        end
    endfunction

    function automatic int valid_slots();
        int n = 0;
        for (int i = 0; i < SLOTS; i++) n += trk_valid[i];
        return n;
    endfunction

    // chain of exact offset matches from zero must visit every valid slot
    function automatic bit message_whole();
        bit     seen [SLOTS];
        longint covered = 0;
        int     n = valid_slots();
        int     hit;
        if (!trk_final) return 0;
        for (int i = 0; i < SLOTS; i++) seen[i] = 0;
        for (int k = 0; k < n; k++) begin
            hit = -1;
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && trk_valid[i] && !seen[i] && longint'(trk_start[i]) == covered)
                    hit = i;
            if (hit < 0) return 0;
            seen[hit] = 1;
            covered += trk_len[hit];
        end
        return covered == longint'(trk_size);
    endfunction

    function automatic t_result predict_tracker(t_item it);
        t_result r;
        int      s;
        int      hit;
        logic [2:0] st = ST_OK;
        logic [7:0] rd = '0;
        case (it.op)
            OP_SEG_BYTE: begin
                s = 0;
                if (!trk_filling) begin
                    trk_started = 1'b1;
                    s = claim_slot(it.seg_off);
                    if (s >= 0) begin
                        trk_filling = 1'b1;
                        trk_fill    = s;
                    end else begin
                        st = ST_FULL;
                    end
                end
                if (s >= 0) begin
                    if (trk_len[trk_fill] < SEG_BYTES) begin
                        trk_bytes[trk_fill*SEG_BYTES + trk_len[trk_fill]] = it.data;
                        trk_len[trk_fill]++;
                    end else begin
                        st = ST_TOO_LONG;
                    end
                    if (it.seg_end) begin
                        trk_filling = 1'b0;
                        close_segment(trk_fill, it.more);
                    end
                end
            end
            OP_EMPTY_SEG: begin
                trk_filling = 1'b0;
                trk_started = 1'b1;
                s = claim_slot(it.seg_off);
                if (s < 0) st = ST_FULL;
                else close_segment(s, it.more);
            end
            OP_TICK: begin
                if (trk_started && trk_elapsed != 32'hFFFF_FFFF) trk_elapsed++;
            end
            OP_CLEAR: clear_tracker();
            OP_READ: begin
                if (!message_whole()) begin
                    st = ST_INCOMPL;
                end else if (32'(it.idx) >= trk_size) begin
                    st = ST_BEYOND;
                end else begin
                    hit = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && trk_valid[i] && trk_len[i] > 0 &&
                            longint'(it.idx) >= longint'(trk_start[i]) &&
                            longint'(it.idx) - longint'(trk_start[i]) < trk_len[i])
                            hit = i;
                    if (hit < 0) st = ST_BEYOND;
                    else rd = trk_bytes[hit*SEG_BYTES + (int'(it.idx) - int'(trk_start[hit]))];
                end
            end
            default: ;
        endcase
        r.complete  = message_whole();
        r.timed_out = trk_started && (trk_elapsed > trk_timeout);
        r.count     = 5'(valid_slots());
        r.size      = trk_size;
        r.rdata     = rd;
        r.status    = st;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("[%0t] mismatch on result %0d: %s got %0h want %0h",
                 $realtime, results_seen, what, got, want);
    endtask

    // ---------------- driver ----------------
    // idling is off in a calm window so back-to-back transfers also occur
    function automatic bit take_break();
        if (cycle >= 3000 && cycle < 9000) return 0;
        return $urandom_range(99) < 13;
    endfunction

    t_item on_bus;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results = {expected_results, predict_tracker(on_bus)};
                accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && !take_break()) begin
                    on_bus = pending_items.pop_front();
                    s_axis_tdata  <= {1'b0, on_bus.idx, on_bus.data, on_bus.more,
                                      on_bus.seg_off};
                    s_axis_tuser  <= on_bus.op;
                    s_axis_tlast  <= on_bus.seg_end;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !take_break();
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", m_axis_tdata, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (m_axis_tdata[0] != w.complete)
                        report_mismatch("complete", m_axis_tdata[0], w.complete);
                    if (m_axis_tdata[1] != w.timed_out)
                        report_mismatch("timed_out", m_axis_tdata[1], w.timed_out);
                    if (m_axis_tdata[6:2] != w.count)
                        report_mismatch("segment_count", m_axis_tdata[6:2], w.count);
                    if (m_axis_tdata[38:7] != w.size)
                        report_mismatch("expected_size", m_axis_tdata[38:7], w.size);
                    if (m_axis_tdata[46:39] != w.rdata)
                        report_mismatch("read_data", m_axis_tdata[46:39], w.rdata);
                    if (m_axis_tuser != w.status)
                        report_mismatch("status", m_axis_tuser, w.status);
                    if (w.complete) completes_seen++;
                    if (w.status == ST_OK && m_axis_tdata[46:39] != 0) good_reads++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    int queued = 0;

    function automatic void add_item(logic [2:0] op, logic [31:0] off, logic more,
                                     logic [7:0] data, logic seg_end, logic [13:0] idx);
        t_item it;
        it.op = op; it.seg_off = off; it.more = more;
        it.data = data; it.seg_end = seg_end; it.idx = idx;
        pending_items = {pending_items, it};
        queued++;
    endfunction

    // one segment, byte by byte; later bytes carry junk offsets that must be ignored
    function automatic void add_segment(logic [31:0] off, int len, logic more);
        if (len == 0) begin
            add_item(OP_EMPTY_SEG, off, more, 8'($urandom), 1'($urandom), 14'($urandom));
        end else begin
            for (int b = 0; b < len; b++)
                add_item(OP_SEG_BYTE, (b == 0) ? off : $urandom,
                         (b == len - 1) ? more : 1'($urandom), 8'($urandom), b == len - 1,
                         14'($urandom));
        end
    endfunction

    // a message cut into segments, mostly well formed, sometimes reordered,
    // repeated, shifted or short of its tail
    function automatic void add_message();
        int        nseg = ($urandom_range(9) == 0) ? $urandom_range(14, 18)
                                                   : $urandom_range(1, 5);
        int        lens [];
        int        offs [];
        int        order [];
        int        tmp, j, total = 0;
        lens  = new[nseg];
        offs  = new[nseg];
        order = new[nseg];
        for (int i = 0; i < nseg; i++) begin
            lens[i] = (i == nseg - 1 && $urandom_range(5) == 0) ? 0 : $urandom_range(1, 6);
            offs[i] = total + (($urandom_range(15) == 0) ? 1 : 0);
            total  += lens[i];
            order[i] = i;
        end
        if ($urandom_range(3) == 0)
            for (int i = nseg - 1; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = order[i]; order[i] = order[j]; order[j] = tmp;
            end
        if ($urandom_range(9) != 0)
            add_item(OP_CLEAR, $urandom, 1'($urandom), 8'($urandom), 1'($urandom),
                     14'($urandom));
        for (int i = 0; i < nseg; i++) begin
            if (i == nseg - 1 && $urandom_range(9) == 0) continue;
            add_segment(offs[order[i]], lens[order[i]], order[i] != nseg - 1);
            if ($urandom_range(7) == 0)
                add_segment(offs[order[i]], lens[order[i]], order[i] != nseg - 1);
            if ($urandom_range(4) == 0)
                add_item(OP_TICK, $urandom, 1'($urandom), 8'($urandom), 1'($urandom),
                         14'($urandom));
        end
        for (int i = 0; i < 4; i++)
            add_item(OP_READ, $urandom, 1'($urandom), 8'($urandom), 1'($urandom),
                     ($urandom_range(7) == 0) ? 14'($urandom) : 14'($urandom_range(total + 1)));
    endfunction

    function automatic void add_noise();
        int n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            add_item(3'($urandom_range(7)),
                     ($urandom_range(1) == 0) ? $urandom : $urandom_range(8),
                     1'($urandom), 8'($urandom), 1'($urandom), 14'($urandom));
    endfunction

    task automatic wait_idle();
        wait (accepted == queued && expected_results.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        trk_timeout = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [31:0] limits [5] = '{32'd0, 32'd3, 32'hFFFF_FFFF, 32'd1, 32'd40};
        int          base;
        clear_tracker();
        trk_timeout = 32'd1000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reads before anything, an empty segment, byte extremes,
        // final segment, reads in and past the message, ticks, unused ops,
        // size saturation near the top of the offset range
        add_item(OP_READ, 0, 0, 0, 0, 0);
        add_item(OP_TICK, 0, 0, 0, 0, 0);
        add_item(OP_EMPTY_SEG, 32'd0, 1'b1, 8'h00, 1'b0, 14'h0);
        add_item(OP_SEG_BYTE, 32'd0, 1'b1, 8'h00, 1'b0, 14'h3FFF);
        add_item(OP_SEG_BYTE, 32'hFFFF_FFFF, 1'b0, 8'hFF, 1'b0, 14'h0);
        add_item(OP_SEG_BYTE, 32'd7, 1'b1, 8'h5A, 1'b1, 14'h0);
        add_item(OP_SEG_BYTE, 32'd3, 1'b1, 8'hA5, 1'b0, 14'h0);
        add_item(OP_SEG_BYTE, 32'd0, 1'b0, 8'h3C, 1'b1, 14'h0);
        add_item(OP_READ, 0, 0, 0, 0, 14'd0);
        add_item(OP_READ, 0, 0, 0, 0, 14'd4);
        add_item(OP_READ, 0, 0, 0, 0, 14'd5);
        add_item(OP_READ, 0, 0, 0, 0, 14'h3FFF);
        add_item(OP_TICK, 0, 0, 0, 0, 0);
        add_item(3'd5, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1, 14'h3FFF);
        add_item(3'd6, 0, 0, 0, 0, 0);
        add_item(3'd7, 0, 0, 0, 0, 0);
        add_item(OP_SEG_BYTE, 32'd3, 1'b1, 8'h11, 1'b0, 14'h0);   // cut short by empty segment
        add_item(OP_EMPTY_SEG, 32'hFFFF_FFFE, 1'b0, 0, 0, 0);
        add_item(OP_CLEAR, 0, 0, 0, 0, 0);
        add_segment(32'hFFFF_FFFE, 4, 1'b0);                       // saturating size
        add_item(OP_CLEAR, 0, 0, 0, 0, 0);
        wait_idle();

        // table full, then one segment past the per-slot byte limit
        write_timeout(limits[0]);
        for (int i = 0; i < SLOTS + 2; i++) add_item(OP_EMPTY_SEG, 32'(i * 2), 1'b1, 0, 0, 0);
        add_item(OP_SEG_BYTE, 32'd100, 1'b1, 8'h77, 1'b1, 0);
        add_item(OP_TICK, 0, 0, 0, 0, 0);
        add_item(OP_CLEAR, 0, 0, 0, 0, 0);
        add_segment(32'd0, SEG_BYTES + 6, 1'b0);
        add_item(OP_READ, 0, 0, 0, 0, 14'd1023);
        add_item(OP_READ, 0, 0, 0, 0, 14'd1024);
        wait_idle();

        // random phases, each under its own timeout setting
        base = queued;
        for (int p = 1; p < 5; p++) begin
            write_timeout(limits[p]);
            while (queued < base + p * (TARGET - base) / 4) begin
                if ($urandom_range(9) < 7) add_message();
                else add_noise();
                for (int t = $urandom_range(3); t > 0; t--)
                    add_item(OP_TICK, $urandom, 1'($urandom), 8'($urandom), 1'($urandom),
                             14'($urandom));
            end
            wait_idle();
        end

        $display("covered %0d transfers: %0d complete-message results, %0d nonzero reads",
                 accepted, completes_seen, good_reads);
        $display("timeout settings 0, 1, 3, 40, 1000 and all ones; %0d mismatches",
                 error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d transfers still expected", expected_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
